>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the vector length block.
// Included by modules that carry concurrent checks; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLK(label, clk, rst_n, !(cond))
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> src/vln_pkg.sv
// Constants, types and step functions for the vector length and normalize pipeline.
// No dependencies.
`timescale 1ns / 1ps
package vln_pkg;
  localparam int unsigned NumComp   = 4;
  localparam int unsigned CompW     = 32;
  localparam int unsigned LenW      = 33;
  localparam int unsigned UnitW     = 18;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned QuotW     = 17;
  localparam int unsigned FracBits  = 16;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sq_res_t;

  typedef struct packed {
    logic [32:0] rem;
    logic        qbit;
  } dv_res_t;

  // one result bit of the digit-by-digit square root
  function automatic sq_res_t sqrt_step(input logic [33:0] rem, input logic [31:0] root,
                                        input logic [1:0] pair);
    logic [34:0] r2;
    logic [34:0] trial;
    sq_res_t     res;
    r2    = {rem[32:0], pair};
    trial = {1'b0, root, 2'b01};
    if (r2 >= trial) begin
      res.rem  = 34'(r2 - trial);
      res.root = {root[30:0], 1'b1};
    end else begin
      res.rem  = r2[33:0];
      res.root = {root[30:0], 1'b0};
    end
    return res;
  endfunction

  // one quotient bit of restoring division
  function automatic dv_res_t div_step(input logic [32:0] rem, input logic [32:0] dvs,
                                       input logic nbit);
    logic [33:0] r2;
    dv_res_t     res;
    r2 = {rem, nbit};
    if (r2 >= {1'b0, dvs}) begin
      res.rem  = 33'(r2 - {1'b0, dvs});
      res.qbit = 1'b1;
    end else begin
      res.rem  = r2[32:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction
endpackage

>>> src/vln_if.sv
// Handshake channels of the vector length block: input vector and result item.
// Depends on nothing.
`timescale 1ns / 1ps
interface vln_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic signed [31:0] comp_w;
  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vln_out_if;
  logic               valid;
  logic               ready;
  logic        [32:0] vec_length;
  logic signed [17:0] unit_x;
  logic signed [17:0] unit_y;
  logic signed [17:0] unit_z;
  logic signed [17:0] unit_w;
  logic               is_zero;
  modport source (output valid, vec_length, unit_x, unit_y, unit_z, unit_w, is_zero,
                  input ready);
  modport sink   (input valid, vec_length, unit_x, unit_y, unit_z, unit_w, is_zero,
                  output ready);
endinterface

>>> src/vector4_length_normalize.sv
// Four-component vector length and normalization, fixed point.
//
// Input channel in_i carries one vector of four signed Q16.16 components.
// Output channel out_o carries the length (unsigned Q17.16, floor of the
// square root of the sum of squares), four unit components in signed Q2.16
// truncated toward zero, and a flag set for the zero vector.
// Throughput: one item per cycle unless out_o holds an untaken result. The
// result reaches out_o through the magnitude, square, pair sum and sum registers,
// 32 square root stages (one root bit each), 17 division stages per lane
// (one quotient bit each) and the output register.
// Every stage moves together on one advance enable; while out_o holds an
// untaken result the whole pipe holds and in_i.ready is low, and while it
// holds no result, ready stays high. Nothing is dropped or repeated.
// Reset clears all valid bits; data registers are not reset.
// Depends on vln_pkg, vln_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vector4_length_normalize
  import vln_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  vln_in_if.sink    in_i,
  vln_out_if.source out_o
);
  localparam int unsigned PreStg = 4;
  localparam int unsigned NumVld = PreStg + SqrtSteps + QuotW + 1;

  logic              adv;
  logic [NumVld-1:0] vld_q;

  logic [CompW-1:0]  comp_in [NumComp];
  logic [CompW-1:0]  a_mag_q [NumComp];
  logic              a_neg_q [NumComp];
  logic [63:0]       b_sq_q  [NumComp];
  logic [CompW-1:0]  b_mag_q [NumComp];
  logic              b_neg_q [NumComp];
  logic [64:0]       c_ps_q  [2];
  logic [CompW-1:0]  c_mag_q [NumComp];
  logic              c_neg_q [NumComp];
  logic [63:0]       d_sum_q;
  logic              d_full_q;
  logic [CompW-1:0]  d_mag_q [NumComp];
  logic              d_neg_q [NumComp];

  logic [33:0]       e_rem_q  [SqrtSteps];
  logic [31:0]       e_root_q [SqrtSteps];
  logic [63:0]       e_s_q    [SqrtSteps];
  logic              e_full_q [SqrtSteps];
  logic [CompW-1:0]  e_mag_q  [SqrtSteps][NumComp];
  logic              e_neg_q  [SqrtSteps][NumComp];

  logic [32:0]       f_rem_q  [QuotW][NumComp];
  logic [QuotW-1:0]  f_n_q    [QuotW][NumComp];
  logic [QuotW-1:0]  f_qt_q   [QuotW][NumComp];
  logic              f_neg_q  [QuotW][NumComp];
  logic [LenW-1:0]   f_len_q  [QuotW];

  logic [LenW-1:0]   o_len_q;
  logic [UnitW-1:0]  o_unit_q [NumComp];
  logic              o_zero_q;

  logic [LenW-1:0]   sq_len;

  assign adv        = !vld_q[NumVld-1] || out_o.ready;
  assign in_i.ready = adv;

  assign comp_in[0] = in_i.comp_x;
  assign comp_in[1] = in_i.comp_y;
  assign comp_in[2] = in_i.comp_z;
  assign comp_in[3] = in_i.comp_w;

  // the only sum that overflows 64 bits is exactly 2^64
  assign sq_len = e_full_q[SqrtSteps-1] ? {1'b1, 32'd0} : {1'b0, e_root_q[SqrtSteps-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumVld-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumComp; i++) begin
        a_mag_q[i] <= comp_in[i][CompW-1] ? (~comp_in[i] + 32'd1) : comp_in[i];
        a_neg_q[i] <= comp_in[i][CompW-1];
        b_sq_q[i]  <= a_mag_q[i] * a_mag_q[i];
        b_mag_q[i] <= a_mag_q[i];
        b_neg_q[i] <= a_neg_q[i];
        c_mag_q[i] <= b_mag_q[i];
        c_neg_q[i] <= b_neg_q[i];
        d_mag_q[i] <= c_mag_q[i];
        d_neg_q[i] <= c_neg_q[i];
      end
      c_ps_q[0] <= {1'b0, b_sq_q[0]} + {1'b0, b_sq_q[1]};
      c_ps_q[1] <= {1'b0, b_sq_q[2]} + {1'b0, b_sq_q[3]};
      {d_full_q, d_sum_q} <= c_ps_q[0] + c_ps_q[1];

      // square root: one root bit per stage
      {e_rem_q[0], e_root_q[0]} <= sqrt_step(34'd0, 32'd0, d_sum_q[63:62]);
      e_s_q[0]    <= {d_sum_q[61:0], 2'b00};
      e_full_q[0] <= d_full_q;
      e_mag_q[0]  <= d_mag_q;
      e_neg_q[0]  <= d_neg_q;
      for (int k = 1; k < SqrtSteps; k++) begin
        {e_rem_q[k], e_root_q[k]} <= sqrt_step(e_rem_q[k-1], e_root_q[k-1], e_s_q[k-1][63:62]);
        e_s_q[k]    <= {e_s_q[k-1][61:0], 2'b00};
        e_full_q[k] <= e_full_q[k-1];
        e_mag_q[k]  <= e_mag_q[k-1];
        e_neg_q[k]  <= e_neg_q[k-1];
      end

      // division: one quotient bit per stage and lane; dividend is mag << 16
      f_len_q[0] <= sq_len;
      for (int i = 0; i < NumComp; i++) begin
        {f_rem_q[0][i], f_qt_q[0][i][0]} <=
          div_step({2'b00, e_mag_q[SqrtSteps-1][i][CompW-1:1]}, sq_len,
                   e_mag_q[SqrtSteps-1][i][0]);
        f_qt_q[0][i][QuotW-1:1] <= '0;
        f_n_q[0][i] <= '0;
        f_neg_q[0][i] <= e_neg_q[SqrtSteps-1][i];
      end
      for (int k = 1; k < QuotW; k++) begin
        f_len_q[k] <= f_len_q[k-1];
        for (int i = 0; i < NumComp; i++) begin
          {f_rem_q[k][i], f_qt_q[k][i][0]} <=
            div_step(f_rem_q[k-1][i], f_len_q[k-1], f_n_q[k-1][i][QuotW-1]);
          f_qt_q[k][i][QuotW-1:1] <= f_qt_q[k-1][i][QuotW-2:0];
          f_n_q[k][i]   <= {f_n_q[k-1][i][QuotW-2:0], 1'b0};
          f_neg_q[k][i] <= f_neg_q[k-1][i];
        end
      end

      // output register: length, zero flag and signed units; zero length drops the quotient
      o_len_q  <= f_len_q[QuotW-1];
      o_zero_q <= (f_len_q[QuotW-1] == '0);
      for (int i = 0; i < NumComp; i++) begin
        if (f_len_q[QuotW-1] == '0) begin
          o_unit_q[i] <= '0;
        end else if (f_neg_q[QuotW-1][i]) begin
          o_unit_q[i] <= 18'(~{1'b0, f_qt_q[QuotW-1][i]} + 18'd1);
        end else begin
          o_unit_q[i] <= {1'b0, f_qt_q[QuotW-1][i]};
        end
      end
    end
  end

  assign out_o.valid      = vld_q[NumVld-1];
  assign out_o.vec_length = o_len_q;
  assign out_o.unit_x     = o_unit_q[0];
  assign out_o.unit_y     = o_unit_q[1];
  assign out_o.unit_z     = o_unit_q[2];
  assign out_o.unit_w     = o_unit_q[3];
  assign out_o.is_zero    = o_zero_q;

  `ASSERT_CLK(a_zero_flag, clk_i, rst_ni,
    out_o.valid |-> (out_o.is_zero == (out_o.vec_length == '0)))
  `ASSERT_NEVER(a_zero_units, clk_i, rst_ni,
    out_o.valid && out_o.is_zero && (out_o.unit_x != '0 || out_o.unit_w != '0))
  `ASSERT_CLK(a_hold_pipe, clk_i, rst_ni, !adv |=> $stable(vld_q))
  `ASSERT_NEVER(a_unit_range, clk_i, rst_ni,
    out_o.valid && (out_o.unit_x > 18'sd65536 || out_o.unit_x < -18'sd65536))
endmodule

>>> dv/vector4_length_normalize_tb.sv
// Self-checking testbench for the four-component vector length and normalize pipeline.
// Depends on vln_pkg, vln_if and the vector4_length_normalize RTL.
`timescale 1ns / 1ps
module vector4_length_normalize_tb;
  import vln_pkg::*;

  typedef struct packed {
    logic [32:0]        vec_length;
    logic signed [17:0] unit_x;
    logic signed [17:0] unit_y;
    logic signed [17:0] unit_z;
    logic signed [17:0] unit_w;
    logic               is_zero;
  } norm_res_t;

  localparam int unsigned Latency   = 54;
  localparam int unsigned CycleCap  = 200000;

  logic clk_i;
  logic rst_ni;
  vln_in_if  in_ch ();
  vln_out_if out_ch ();

  vector4_length_normalize dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  norm_res_t   expected_q[$];
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_zero;
  int unsigned cycle_cnt;
  bit          hold_off;
  int unsigned sink_max_wait;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // floor of the square root of a 65-bit sum, one bit at a time
  function automatic logic [32:0] root_floor(input logic [64:0] s);
    logic [32:0] r;
    logic [32:0] t;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (33'd1 << b);
      if ({65'd0, t} * {65'd0, t} <= {65'd0, s}) r = t;
    end
    return r;
  endfunction

  function automatic norm_res_t normalize(input logic signed [31:0] c[4]);
    norm_res_t   res;
    logic [64:0] sum;
    logic [32:0] mag;
    logic [48:0] quo;
    logic [17:0] u[4];
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      mag = c[i][31] ? 33'(-{1'b1, c[i]}) : {1'b0, c[i]};
      sum += 65'(mag) * 65'(mag);
    end
    res.vec_length = root_floor(sum);
    for (int i = 0; i < 4; i++) begin
      mag = c[i][31] ? 33'(-{1'b1, c[i]}) : {1'b0, c[i]};
      if (res.vec_length == 0) u[i] = '0;
      else begin
        quo  = {mag, 16'd0} / 49'(res.vec_length);
        u[i] = c[i][31] ? 18'(-quo) : 18'(quo);
      end
    end
    res.unit_x  = u[0];
    res.unit_y  = u[1];
    res.unit_z  = u[2];
    res.unit_w  = u[3];
    res.is_zero = (res.vec_length == 0);
    return res;
  endfunction

  task automatic send_vector(input logic signed [31:0] c[4], input int unsigned max_gap);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.comp_x <= c[0];
    in_ch.comp_y <= c[1];
    in_ch.comp_z <= c[2];
    in_ch.comp_w <= c[3];
    expected_q.push_back(normalize(c));
    n_sent++;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    idle_input();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(0, 8)) - 32'd4);
      3: return $signed(32'($urandom) >>> $urandom_range(0, 31));
      default: return $signed(32'($urandom));
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] c[4];
    logic signed [31:0] corner[6];
    corner = '{32'sh0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh1, -32'sh1, 32'sh0001_0000};
    // zero vector and the negative and positive full-scale vectors
    c = '{0, 0, 0, 0};
    send_vector(c, 0);
    c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    send_vector(c, 0);
    c = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    send_vector(c, 1);
    for (int i = 0; i < 18; i++) begin
      foreach (c[k]) c[k] = corner[(i + k * (i / 6 + 1)) % 6];
      send_vector(c, i % 3);
    end
    c = '{32'sh0, 32'sh0, 32'sh0, 32'sh8000_0000};
    send_vector(c, 0);
    c = '{-32'sh1, 32'sh0, 32'sh0, 32'sh0};
    send_vector(c, 0);
    drain();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned max_gap);
    logic signed [31:0] c[4];
    for (int i = 0; i < count; i++) begin
      foreach (c[k]) c[k] = rand_comp();
      send_vector(c, ($urandom_range(0, 3) == 0) ? 0 : max_gap);
    end
    idle_input();
  endtask

  // stall the output long enough for the pipe to fill and hold the input
  task automatic test_backpressure();
    logic signed [31:0] c[4];
    hold_off = 1'b1;
    for (int i = 0; i < 80; i++) begin
      foreach (c[k]) c[k] = rand_comp();
      send_vector(c, 0);
    end
    idle_input();
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.comp_x  = '0;
    in_ch.comp_y  = '0;
    in_ch.comp_z  = '0;
    in_ch.comp_w  = '0;
    n_errors      = 0;
    n_sent        = 0;
    sink_max_wait = 11;
    hold_off      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250, 11);
    drain();
    test_backpressure();
    sink_max_wait = 0;
    test_random(150, 0);
    sink_max_wait = 11;
    test_random(150, 3);
    drain();
    repeat (Latency + 10) @(posedge clk_i);
    $display("Sent %0d vectors, checked %0d results (%0d zero-length), incl. full-scale",
             n_sent, n_checked, n_zero);
    $display("and back-pressure with the input held off by a full pipe.");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result sink: random stalls, plus one long hold-off
  initial begin
    int unsigned wait_cnt;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        for (wait_cnt = 0; wait_cnt < 300; wait_cnt++) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_cnt = $urandom_range(0, sink_max_wait);
      if (wait_cnt > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cnt) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    norm_res_t got;
    norm_res_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.vec_length, out_ch.unit_x, out_ch.unit_y, out_ch.unit_z,
              out_ch.unit_w, out_ch.is_zero};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        n_checked++;
        if (exp_r.is_zero) n_zero++;
        if (got.vec_length !== exp_r.vec_length)
          $display("%0t: vec_length expected %0d actual %0d", $time, exp_r.vec_length,
                   got.vec_length);
        if (got.unit_x !== exp_r.unit_x)
          $display("%0t: unit_x expected %0d actual %0d", $time, exp_r.unit_x, got.unit_x);
        if (got.unit_y !== exp_r.unit_y)
          $display("%0t: unit_y expected %0d actual %0d", $time, exp_r.unit_y, got.unit_y);
        if (got.unit_z !== exp_r.unit_z)
          $display("%0t: unit_z expected %0d actual %0d", $time, exp_r.unit_z, got.unit_z);
        if (got.unit_w !== exp_r.unit_w)
          $display("%0t: unit_w expected %0d actual %0d", $time, exp_r.unit_w, got.unit_w);
        if (got.is_zero !== exp_r.is_zero)
          $display("%0t: is_zero expected %0b actual %0b", $time, exp_r.is_zero,
                   got.is_zero);
        if (got !== exp_r) n_errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cycle_cnt = 0;
    n_checked = 0;
    n_zero    = 0;
  end
endmodule
